### rtl/core/fqa_pkg.sv
package fqa_pkg;

    localparam int FRAC_W      = 24;
    localparam int INT_W       = 18;
    localparam int VEC_W       = INT_W + FRAC_W;
    localparam int ANG_W       = 28;
    localparam int TABLE_LEN   = 24;
    localparam int ROUND_SHIFT = 11;
    localparam int Q_W         = ANG_W - ROUND_SHIFT;
    localparam int OUT_W       = 16;
    localparam int IN_W        = 16;

    localparam int ANGLE_MAX_I   = 25736;
    localparam int HALF_PI_OUT_I = 12868;

    localparam logic signed [ANG_W-1:0] HALF_PI_INT = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] ROUND_BIAS  = 28'sd1024;

    // atan(2^-i) scaled by 2^24
    localparam logic signed [ANG_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef enum logic [2:0] {
        KIND_CORDIC,
        KIND_ORIGIN,
        KIND_POS_Y,
        KIND_NEG_Y,
        KIND_NEG_X,
        KIND_POS_X
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } ctl_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } vec_t;

endpackage

### rtl/core/four_quadrant_arctangent_unit.sv
// Pipeline: input stage, one cell per CORDIC iteration, then a rounding/output
// stage; each stage is registered.
// Throughput: one point per cycle; the whole chain advances when the output
// register is empty or its result is taken, so in_stall follows out_stall.
// Reset clears all valid bits asynchronously; datapath registers are not reset.
module four_quadrant_arctangent_unit
#(
    parameter int ITERATIONS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [fqa_pkg::IN_W-1:0]   x_coord,
    input  logic signed [fqa_pkg::IN_W-1:0]   y_coord,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fqa_pkg::OUT_W-1:0]  angle,
    output logic                              origin_flag
);

    fqa_pkg::ctl_t ctl_s [ITERATIONS+1];
    fqa_pkg::vec_t vec_s [ITERATIONS+1];
    logic          adv;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    fqa_prerot u_prerot
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .ctl_out  (ctl_s[0]),
        .vec_out  (vec_s[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_cell
        fqa_cell #(.STEP(g)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_s[g]),
            .vec_in  (vec_s[g]),
            .ctl_out (ctl_s[g+1]),
            .vec_out (vec_s[g+1])
        );
    end

    fqa_post u_post
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .ctl_in      (ctl_s[ITERATIONS]),
        .vec_in      (vec_s[ITERATIONS]),
        .out_valid   (out_valid),
        .angle       (angle),
        .origin_flag (origin_flag)
    );

endmodule

### rtl/core/fqa_prerot.sv
module fqa_prerot
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  logic signed [fqa_pkg::IN_W-1:0]      x_coord,
    input  logic signed [fqa_pkg::IN_W-1:0]      y_coord,
    output fqa_pkg::ctl_t                        ctl_out,
    output fqa_pkg::vec_t                        vec_out
);

    fqa_pkg::ctl_t ctl_reg;
    fqa_pkg::ctl_t ctl_next;
    fqa_pkg::vec_t vec_reg;
    fqa_pkg::vec_t vec_next;

    logic signed [fqa_pkg::INT_W-1:0] xe;
    logic signed [fqa_pkg::INT_W-1:0] ye;
    logic signed [fqa_pkg::INT_W-1:0] nx;
    logic signed [fqa_pkg::INT_W-1:0] ny;
    logic signed [fqa_pkg::ANG_W-1:0] nz;
    logic                             x_zero;
    logic                             y_zero;

    assign xe = {{(fqa_pkg::INT_W - fqa_pkg::IN_W){x_coord[fqa_pkg::IN_W-1]}}, x_coord};
    assign ye = {{(fqa_pkg::INT_W - fqa_pkg::IN_W){y_coord[fqa_pkg::IN_W-1]}}, y_coord};
    assign x_zero = (x_coord == '0);
    assign y_zero = (y_coord == '0);

    always_comb
    begin
        ctl_next.valid = in_valid;
        if (x_zero && y_zero)
        begin
            ctl_next.kind = fqa_pkg::KIND_ORIGIN;
        end
        else if (x_zero)
        begin
            ctl_next.kind = y_coord[fqa_pkg::IN_W-1] ? fqa_pkg::KIND_NEG_Y : fqa_pkg::KIND_POS_Y;
        end
        else if (y_zero)
        begin
            ctl_next.kind = x_coord[fqa_pkg::IN_W-1] ? fqa_pkg::KIND_NEG_X : fqa_pkg::KIND_POS_X;
        end
        else
        begin
            ctl_next.kind = fqa_pkg::KIND_CORDIC;
        end
    end

    // quarter turn into the right half plane
    always_comb
    begin
        if (xe[fqa_pkg::INT_W-1])
        begin
            if (!ye[fqa_pkg::INT_W-1] && !y_zero)
            begin
                nx = ye;
                ny = -xe;
                nz = fqa_pkg::HALF_PI_INT;
            end
            else
            begin
                nx = -ye;
                ny = xe;
                nz = -fqa_pkg::HALF_PI_INT;
            end
        end
        else
        begin
            nx = xe;
            ny = ye;
            nz = '0;
        end
        vec_next.x = {nx, {fqa_pkg::FRAC_W{1'b0}}};
        vec_next.y = {ny, {fqa_pkg::FRAC_W{1'b0}}};
        vec_next.z = nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign vec_out = vec_reg;

endmodule

### rtl/core/fqa_cell.sv
module fqa_cell
#(
    parameter int STEP = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  fqa_pkg::ctl_t ctl_in,
    input  fqa_pkg::vec_t vec_in,
    output fqa_pkg::ctl_t ctl_out,
    output fqa_pkg::vec_t vec_out
);

    fqa_pkg::ctl_t ctl_reg;
    fqa_pkg::vec_t vec_reg;
    fqa_pkg::vec_t vec_next;

    logic signed [fqa_pkg::VEC_W-1:0] dx;
    logic signed [fqa_pkg::VEC_W-1:0] dy;

    assign dx = vec_in.y >>> STEP;
    assign dy = vec_in.x >>> STEP;

    always_comb
    begin
        if (!vec_in.y[fqa_pkg::VEC_W-1])
        begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + fqa_pkg::ATAN_TABLE[STEP];
        end
        else
        begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - fqa_pkg::ATAN_TABLE[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign vec_out = vec_reg;

endmodule

### rtl/core/fqa_post.sv
module fqa_post
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  fqa_pkg::ctl_t                     ctl_in,
    input  fqa_pkg::vec_t                     vec_in,
    output logic                              out_valid,
    output logic signed [fqa_pkg::OUT_W-1:0]  angle,
    output logic                              origin_flag
);

    localparam logic signed [fqa_pkg::Q_W-1:0] Q_MAX = fqa_pkg::Q_W'(fqa_pkg::ANGLE_MAX_I);
    localparam logic signed [fqa_pkg::Q_W-1:0] Q_MIN = -Q_MAX;
    localparam logic signed [fqa_pkg::OUT_W-1:0] A_MAX = fqa_pkg::OUT_W'(fqa_pkg::ANGLE_MAX_I);
    localparam logic signed [fqa_pkg::OUT_W-1:0] A_HALF =
        fqa_pkg::OUT_W'(fqa_pkg::HALF_PI_OUT_I);

    logic                              valid_reg;
    logic signed [fqa_pkg::OUT_W-1:0]  angle_reg;
    logic signed [fqa_pkg::OUT_W-1:0]  angle_next;
    logic                              flag_reg;
    logic                              flag_next;
    logic signed [fqa_pkg::ANG_W-1:0]  sum;
    logic signed [fqa_pkg::Q_W-1:0]    q;
    logic signed [fqa_pkg::OUT_W-1:0]  q_sat;

    // round half up to Q3.13, then clamp to +-pi
    assign sum = vec_in.z + fqa_pkg::ROUND_BIAS;
    assign q   = sum[fqa_pkg::ANG_W-1:fqa_pkg::ROUND_SHIFT];

    always_comb
    begin
        if (q > Q_MAX)
        begin
            q_sat = A_MAX;
        end
        else if (q < Q_MIN)
        begin
            q_sat = -A_MAX;
        end
        else
        begin
            q_sat = q[fqa_pkg::OUT_W-1:0];
        end
    end

    always_comb
    begin
        flag_next = 1'b0;
        case (ctl_in.kind)
            fqa_pkg::KIND_ORIGIN:
            begin
                angle_next = '0;
                flag_next  = 1'b1;
            end
            fqa_pkg::KIND_POS_Y: angle_next = A_HALF;
            fqa_pkg::KIND_NEG_Y: angle_next = -A_HALF;
            fqa_pkg::KIND_NEG_X: angle_next = A_MAX;
            fqa_pkg::KIND_POS_X: angle_next = '0;
            default:             angle_next = q_sat;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_reg <= angle_next;
            flag_reg  <= flag_next;
        end
    end

    assign out_valid   = valid_reg;
    assign angle       = angle_reg;
    assign origin_flag = flag_reg;

endmodule

### rtl/core/fqa_checker.sv
module fqa_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [fqa_pkg::IN_W-1:0]   x_coord,
    input  logic signed [fqa_pkg::IN_W-1:0]   y_coord,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [fqa_pkg::OUT_W-1:0]  angle,
    input  logic                              origin_flag
);

    localparam logic signed [fqa_pkg::OUT_W-1:0] A_MAX = fqa_pkg::OUT_W'(fqa_pkg::ANGLE_MAX_I);

    logic unused_in;
    assign unused_in = in_valid ^ (^x_coord) ^ (^y_coord);

    // the chain only blocks when a finished result is held
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without a held result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle) && $stable(origin_flag))
        else $error("held result changed");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && origin_flag |-> angle == '0)
        else $error("origin result with nonzero angle");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle <= A_MAX) && (angle >= -A_MAX))
        else $error("angle beyond pi");

endmodule

bind four_quadrant_arctangent_unit fqa_checker u_fqa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .angle       (angle),
    .origin_flag (origin_flag)
);
